@@ sv/wheel_speed_incremental_pid_assert.svh @@
// Assertion helpers shared by the RTL.
`ifndef WHEEL_SPEED_INCREMENTAL_PID_ASSERT_SVH
`define WHEEL_SPEED_INCREMENTAL_PID_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define WSIP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wsip assertion failed");

// Next-cycle implication, disabled in reset.
`define WSIP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wsip assertion failed");

`endif

@@ sv/wsip_pkg.sv @@
package wsip_pkg;

    localparam int DATA_W   = 16;
    localparam int GAIN_W   = 24;
    localparam int CFG_W    = 24;
    localparam int IDX_W    = 3;
    localparam int LIMIT_W  = 15;
    localparam int MUL_A_W  = GAIN_W + 1;
    localparam int MUL_B_W  = DATA_W + 2;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int STEP_SH  = 20;
    localparam int SPEED_SH = 4;

    localparam logic [GAIN_W-1:0]  GAIN_P_RST      = 24'd256000;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 24'd2560;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 24'd0;
    localparam logic [DATA_W-1:0]  SPEED_SCALE_RST = 16'd1114;
    localparam logic [DATA_W-1:0]  ERROR_FLOOR_RST = 16'hF800;
    localparam logic [LIMIT_W-1:0] DUTY_LIMIT_RST  = 15'd4000;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_SPEED_SCALE = 3'd3,
        REG_ERROR_FLOOR = 3'd4,
        REG_DUTY_LIMIT  = 3'd5,
        REG_OFFSET_MODE = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPEED,
        S_ERR,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_STEP
    } state_t;

    typedef struct packed {
        logic load_prod;
        logic clr_acc;
        logic add_acc;
    } mac_ctrl_t;

endpackage

@@ sv/wheel_speed_incremental_pid.sv @@
// Accepts a new input only while idle, so one item is in flight at a time; one
// shared 25x18 multiplier with an accumulator runs four multiplies in turn under
// the sequencer.
// Reset (aresetn low, synchronous): registers to defaults, error history,
// duty accumulator and direction cleared, no result pending.
`include "wheel_speed_incremental_pid_assert.svh"

module wheel_speed_incremental_pid (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [wsip_pkg::IDX_W-1:0]         cfg_index,
    input  logic [wsip_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [wsip_pkg::DATA_W-1:0] s_target_speed,
    input  logic signed [wsip_pkg::DATA_W-1:0] s_steer_offset,
    input  logic signed [wsip_pkg::DATA_W-1:0] s_encoder_count,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [wsip_pkg::DATA_W-1:0] m_duty,
    output logic [wsip_pkg::LIMIT_W-1:0]       m_duty_magnitude,
    output logic                               m_reverse
);

    localparam int DW = wsip_pkg::DATA_W;
    localparam int EW = wsip_pkg::PROD_W - wsip_pkg::SPEED_SH + 1;
    localparam int SW = wsip_pkg::ACC_W - wsip_pkg::STEP_SH;

    logic [wsip_pkg::GAIN_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic [DW-1:0]                speed_scale_reg;
    logic signed [DW-1:0]         error_floor_reg;
    logic [wsip_pkg::LIMIT_W-1:0] duty_limit_reg;
    logic                         offset_mode_reg;

    wsip_pkg::state_t state_reg, state_next;

    logic signed [DW-1:0] target_reg, offset_reg, count_reg;
    logic signed [DW-1:0] err_reg, err_next;
    logic signed [DW:0]   d1_reg;
    logic signed [DW+1:0] d2_reg;
    logic signed [DW-1:0] prev_error_reg, prev_prev_error_reg, duty_accum_reg;
    logic                 direction_reg;
    logic                 m_valid_reg;
    logic signed [DW-1:0] m_duty_reg;
    logic [wsip_pkg::LIMIT_W-1:0] m_mag_reg;

    wsip_pkg::mac_ctrl_t                 mac_ctrl;
    logic signed [wsip_pkg::MUL_A_W-1:0] mac_a;
    logic signed [wsip_pkg::MUL_B_W-1:0] mac_b;
    logic signed [wsip_pkg::PROD_W-1:0]  prod;
    logic signed [wsip_pkg::ACC_W-1:0]   acc;

    logic signed [DW:0]   goal;
    logic signed [EW-1:0] speed, err_wide;
    logic signed [wsip_pkg::ACC_W-1:0] acc_adj;
    logic signed [SW-1:0] step_wide;
    logic signed [DW-1:0] step;
    logic signed [DW:0]   duty_sum, limit_pos;
    logic signed [DW-1:0] duty_new;
    logic                 step_go;

    wsip_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .prod (prod),
        .acc  (acc)
    );

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg      <= wsip_pkg::GAIN_P_RST;
            gain_i_reg      <= wsip_pkg::GAIN_I_RST;
            gain_d_reg      <= wsip_pkg::GAIN_D_RST;
            speed_scale_reg <= wsip_pkg::SPEED_SCALE_RST;
            error_floor_reg <= wsip_pkg::ERROR_FLOOR_RST;
            duty_limit_reg  <= wsip_pkg::DUTY_LIMIT_RST;
            offset_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wsip_pkg::REG_GAIN_P:      gain_p_reg      <= cfg_wdata;
                wsip_pkg::REG_GAIN_I:      gain_i_reg      <= cfg_wdata;
                wsip_pkg::REG_GAIN_D:      gain_d_reg      <= cfg_wdata;
                wsip_pkg::REG_SPEED_SCALE: speed_scale_reg <= cfg_wdata[DW-1:0];
                wsip_pkg::REG_ERROR_FLOOR: error_floor_reg <= cfg_wdata[DW-1:0];
                wsip_pkg::REG_DUTY_LIMIT:  duty_limit_reg  <= cfg_wdata[wsip_pkg::LIMIT_W-1:0];
                wsip_pkg::REG_OFFSET_MODE: offset_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Datapath
    always_comb begin
        goal = offset_mode_reg ? (DW+1)'(target_reg) + (DW+1)'(offset_reg)
                               : (DW+1)'(target_reg) - (DW+1)'(offset_reg);
        speed    = EW'(prod >>> wsip_pkg::SPEED_SH);
        err_wide = EW'(goal) - speed;
        if (err_wide < EW'(error_floor_reg)) begin
            err_next = error_floor_reg;
        end else if (err_wide > EW'(16'sh7FFF)) begin
            err_next = 16'sh7FFF;
        end else begin
            err_next = err_wide[DW-1:0];
        end

        // truncate toward zero
        acc_adj   = acc[wsip_pkg::ACC_W-1]
                  ? acc + wsip_pkg::ACC_W'((1 << wsip_pkg::STEP_SH) - 1) : acc;
        step_wide = SW'(acc_adj >>> wsip_pkg::STEP_SH);
        if (step_wide > SW'(16'sh7FFF)) begin
            step = 16'sh7FFF;
        end else if (step_wide < SW'(-17'sd32768)) begin
            step = 16'sh8000;
        end else begin
            step = step_wide[DW-1:0];
        end

        duty_sum  = (DW+1)'(duty_accum_reg) + (DW+1)'(step);
        limit_pos = (DW+1)'({2'b00, duty_limit_reg});
        if (duty_sum > limit_pos) begin
            duty_new = limit_pos[DW-1:0];
        end else if (duty_sum < -limit_pos) begin
            duty_new = DW'(-limit_pos);
        end else begin
            duty_new = duty_sum[DW-1:0];
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wsip_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mac_ctrl   = '0;
        mac_a      = '0;
        mac_b      = '0;
        step_go    = 1'b0;
        s_ready    = 1'b0;
        case (state_reg)
            wsip_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = wsip_pkg::S_SPEED;
                end
            end
            wsip_pkg::S_SPEED: begin
                mac_ctrl.load_prod = 1'b1;
                mac_a      = wsip_pkg::MUL_A_W'({1'b0, speed_scale_reg});
                mac_b      = wsip_pkg::MUL_B_W'(count_reg);
                state_next = wsip_pkg::S_ERR;
            end
            wsip_pkg::S_ERR: begin
                mac_ctrl.clr_acc = 1'b1;
                state_next       = wsip_pkg::S_MUL_P;
            end
            wsip_pkg::S_MUL_P: begin
                mac_ctrl.load_prod = 1'b1;
                mac_a      = {1'b0, gain_p_reg};
                mac_b      = wsip_pkg::MUL_B_W'(d1_reg);
                state_next = wsip_pkg::S_MUL_I;
            end
            wsip_pkg::S_MUL_I: begin
                mac_ctrl.load_prod = 1'b1;
                mac_ctrl.add_acc   = 1'b1;
                mac_a      = {1'b0, gain_i_reg};
                mac_b      = wsip_pkg::MUL_B_W'(err_reg);
                state_next = wsip_pkg::S_MUL_D;
            end
            wsip_pkg::S_MUL_D: begin
                mac_ctrl.load_prod = 1'b1;
                mac_ctrl.add_acc   = 1'b1;
                mac_a      = {1'b0, gain_d_reg};
                mac_b      = d2_reg;
                state_next = wsip_pkg::S_ACC;
            end
            wsip_pkg::S_ACC: begin
                mac_ctrl.add_acc = 1'b1;
                state_next       = wsip_pkg::S_STEP;
            end
            wsip_pkg::S_STEP: begin
                // hold until the previous result has been taken
                if (!m_valid_reg || m_ready) begin
                    step_go    = 1'b1;
                    state_next = wsip_pkg::S_IDLE;
                end
            end
            default: state_next = wsip_pkg::S_IDLE;
        endcase
    end

    // Input capture, error terms and result data
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            target_reg <= s_target_speed;
            offset_reg <= s_steer_offset;
            count_reg  <= s_encoder_count;
        end
        if (state_reg == wsip_pkg::S_ERR) begin
            err_reg <= err_next;
            d1_reg  <= (DW+1)'(err_next) - (DW+1)'(prev_error_reg);
            d2_reg  <= (DW+2)'(err_next) - ((DW+2)'(prev_error_reg) <<< 1)
                     + (DW+2)'(prev_prev_error_reg);
        end
        if (step_go) begin
            m_duty_reg <= duty_new;
            m_mag_reg  <= duty_new[DW-1] ? wsip_pkg::LIMIT_W'(-duty_new)
                                         : duty_new[wsip_pkg::LIMIT_W-1:0];
        end
    end

    // Loop state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg      <= '0;
            prev_prev_error_reg <= '0;
            duty_accum_reg      <= '0;
            direction_reg       <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (step_go) begin
                prev_prev_error_reg <= prev_error_reg;
                prev_error_reg      <= err_reg;
                duty_accum_reg      <= duty_new;
                if (duty_new != '0) begin
                    direction_reg <= duty_new[DW-1];
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_duty           = m_duty_reg;
    assign m_duty_magnitude = m_mag_reg;
    assign m_reverse        = direction_reg;

    `WSIP_ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, s_valid && s_ready, !s_ready)
    `WSIP_ASSERT_SAME(a_result_matches_accum, aclk, aresetn, m_valid_reg, m_duty_reg == duty_accum_reg)
    `WSIP_ASSERT_SAME(a_reverse_tracks_sign, aclk, aresetn, m_valid_reg && (m_duty_reg != '0), m_reverse == m_duty_reg[DW-1])

endmodule

@@ sv/wsip_mac.sv @@
module wsip_mac (
    input  logic                                   aclk,
    input  wsip_pkg::mac_ctrl_t                    ctrl,
    input  logic signed [wsip_pkg::MUL_A_W-1:0]    op_a,
    input  logic signed [wsip_pkg::MUL_B_W-1:0]    op_b,
    output logic signed [wsip_pkg::PROD_W-1:0]     prod,
    output logic signed [wsip_pkg::ACC_W-1:0]      acc
);

    logic signed [wsip_pkg::PROD_W-1:0] prod_reg;
    logic signed [wsip_pkg::ACC_W-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load_prod) begin
            prod_reg <= op_a * op_b;
        end
        if (ctrl.clr_acc) begin
            acc_reg <= '0;
        end else if (ctrl.add_acc) begin
            acc_reg <= acc_reg + wsip_pkg::ACC_W'(prod_reg);
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule
